// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vir_pkg.sv =====
package vir_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] MODE_READ    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_LOCATE  = 2'd2;
    localparam logic [1:0] MODE_CONVERT = 2'd3;

    // Register word offsets that the block decodes.
    localparam logic [3:0] REG_CTRL      = 4'd0;
    localparam logic [3:0] REG_ORIGIN    = 4'd1;
    localparam logic [3:0] REG_WIDTH     = 4'd2;
    localparam logic [3:0] REG_V_INTR    = 4'd3;
    localparam logic [3:0] REG_V_CURRENT = 4'd4;
    localparam logic [3:0] REG_V_SYNC    = 4'd6;
    localparam logic [3:0] REG_H_VIDEO   = 4'd9;
    localparam logic [3:0] REG_V_VIDEO   = 4'd10;
    localparam logic [3:0] REG_X_SCALE   = 4'd12;
    localparam logic [3:0] REG_Y_SCALE   = 4'd13;

    // Pixel format field in the control register.
    localparam logic [1:0] PMODE_32 = 2'd3;

    // Halfline divider: a fixed numerator, one quotient bit per step.
    localparam int unsigned     SYNC_BITS      = 21;
    localparam int unsigned     DIV_CNT_W      = 5;
    localparam logic [20:0]     SYNC_NUMERATOR = 21'd1562500;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = DIV_CNT_W'(SYNC_BITS - 1);

    // Reset and default values.
    localparam logic [11:0] DEFAULT_SCALE   = 12'd512;
    localparam logic [9:0]  INTR_LINE_RESET = 10'd256;

    // Widen a 5-bit color channel to 8 bits by bit replication.
    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

// ===== rtl/video_interface_registers.sv =====
// Video interface register bank with scanout helpers.
// Input channel (in_valid/in_ready) carries one word per operation: register
// read, register write, pixel locate or pixel convert. Output channel
// (out_valid/out_ready) returns exactly one result word per input word, with
// the display size and halfline cycle count as they stand after the operation.
// The block takes one word at a time: in_ready is high only while the sequencer
// is idle. After acceptance a word goes through these steps: the register
// access, then three passes through one shared 12x12 multiplier (pixel index,
// display width, display height), then the output load. A write to the
// vertical sync register with a nonzero divisor adds a restoring division
// before the multiplier passes, one quotient bit per cycle for all 21 bits.
// The result sits in an output register; the next word is accepted while it
// waits, and the sequencer only holds in its final step if the previous
// result has still not been taken when the new one is ready.
// Reset (rst_n low) clears the architectural registers to their reset values
// (interrupt line 256, all others zero) and empties the output register.
`include "assert_macros.svh"
module video_interface_registers
    import vir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic [31:0] pixel_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        irq_clear,
    output logic [23:0] pixel_address,
    output logic [31:0] pixel_color,
    output logic        pixel_valid,
    output logic [11:0] display_width,
    output logic [10:0] display_height,
    output logic [20:0] halfline_cycles
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MADR = 3'd3;
    localparam logic [2:0] ST_MWID = 3'd4;
    localparam logic [2:0] ST_MHGT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;

    // Architectural registers.
    logic [31:0] control_reg;
    logic [23:0] origin_reg;
    logic [11:0] stride_reg;
    logic [9:0]  intr_line_reg;
    logic [9:0]  h_start_reg;
    logic [9:0]  h_end_reg;
    logic [9:0]  v_start_reg;
    logic [9:0]  v_end_reg;
    logic [11:0] x_scale_reg;
    logic [11:0] y_scale_reg;
    logic [20:0] halfline_reg;

    // Captured input word.
    logic [1:0]  mode_reg;
    logic [3:0]  index_reg;
    logic [31:0] wdata_reg;
    logic [11:0] px_reg;
    logic [11:0] py_reg;
    logic [31:0] raw_reg;

    // Working results.
    logic [31:0] rdata_work_reg;
    logic        irq_work_reg;
    logic [23:0] pix_index_reg;
    logic [11:0] dw_work_reg;
    logic [10:0] dh_work_reg;

    // Divider state.
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [30:0] div_den_reg;
    logic [20:0] div_rem_reg;
    logic [19:0] div_quo_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] read_data_reg;
    logic        irq_clear_reg;
    logic [23:0] pixel_address_reg;
    logic [31:0] pixel_color_reg;
    logic        pixel_valid_reg;
    logic [11:0] display_width_reg;
    logic [10:0] display_height_reg;
    logic [20:0] halfline_out_reg;

    logic        in_fire;
    logic        out_load;
    logic        sync_start;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // A sync write with a nonzero divisor starts the divider.
    assign sync_start = (mode_reg == MODE_WRITE) && (index_reg == REG_V_SYNC)
                        && (wdata_reg[31:1] != 31'd0);

    // Register read decode.
    logic [31:0] read_mux;
    always_comb
    begin
        case (index_reg)
            REG_CTRL:    read_mux = control_reg;
            REG_ORIGIN:  read_mux = {8'd0, origin_reg};
            REG_WIDTH:   read_mux = {20'd0, stride_reg};
            REG_V_INTR:  read_mux = {22'd0, intr_line_reg};
            REG_H_VIDEO: read_mux = {6'd0, h_start_reg, 6'd0, h_end_reg};
            REG_V_VIDEO: read_mux = {6'd0, v_start_reg, 6'd0, v_end_reg};
            REG_X_SCALE: read_mux = {20'd0, x_scale_reg};
            REG_Y_SCALE: read_mux = {20'd0, y_scale_reg};
            default:     read_mux = 32'd0;
        endcase
    end

    // One restoring division step: bring down the next numerator bit.
    logic [21:0] div_trial;
    logic [30:0] div_diff;
    logic        div_ge;
    assign div_trial = {div_rem_reg, SYNC_NUMERATOR[div_cnt_reg]};
    assign div_ge    = {9'd0, div_trial} >= div_den_reg;
    assign div_diff  = {9'd0, div_trial} - div_den_reg;

    // Spans and effective scales for the display size.
    logic [9:0]  h_span;
    logic [8:0]  v_half_span;
    logic [9:0]  v_diff;
    logic [11:0] x_eff;
    logic [11:0] y_eff;
    assign h_span      = (h_end_reg > h_start_reg) ? h_end_reg - h_start_reg : 10'd0;
    assign v_diff      = (v_end_reg > v_start_reg) ? v_end_reg - v_start_reg : 10'd0;
    assign v_half_span = v_diff[9:1];
    assign x_eff       = (x_scale_reg != 12'd0) ? x_scale_reg : DEFAULT_SCALE;
    assign y_eff       = (y_scale_reg != 12'd0) ? y_scale_reg : DEFAULT_SCALE;

    // Shared multiplier, operands chosen by the sequencer step.
    logic [11:0] mul_a;
    logic [11:0] mul_b;
    logic [23:0] mul_p;
    always_comb
    begin
        case (state_reg)
            ST_MWID:
            begin
                mul_a = {2'd0, h_span};
                mul_b = x_eff;
            end
            ST_MHGT:
            begin
                mul_a = {3'd0, v_half_span};
                mul_b = y_eff;
            end
            default:
            begin
                mul_a = py_reg;
                mul_b = stride_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Pixel address and color, formed when the result is loaded.
    logic        pix_ok;
    logic        pix_32;
    logic [23:0] addr_calc;
    logic [15:0] raw16_swap;
    logic [31:0] color_calc;
    assign pix_ok     = control_reg[1];
    assign pix_32     = (control_reg[1:0] == PMODE_32);
    assign addr_calc  = origin_reg + (pix_32 ? {pix_index_reg[21:0], 2'b00}
                                             : {pix_index_reg[22:0], 1'b0});
    assign raw16_swap = {raw_reg[7:0], raw_reg[15:8]};
    assign color_calc = pix_32 ? {raw_reg[7:0], raw_reg[15:8], raw_reg[23:16], raw_reg[31:24]}
                               : {8'hFF, widen5(raw16_swap[5:1]), widen5(raw16_swap[10:6]),
                                  widen5(raw16_swap[15:11])};

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EXEC;
            ST_EXEC: state_next = sync_start ? ST_DIV : ST_MADR;
            ST_DIV:  if (div_cnt_reg == '0) state_next = ST_MADR;
            ST_MADR: state_next = ST_MWID;
            ST_MWID: state_next = ST_MHGT;
            ST_MHGT: state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            control_reg   <= 32'd0;
            origin_reg    <= 24'd0;
            stride_reg    <= 12'd0;
            intr_line_reg <= INTR_LINE_RESET;
            h_start_reg   <= 10'd0;
            h_end_reg     <= 10'd0;
            v_start_reg   <= 10'd0;
            v_end_reg     <= 10'd0;
            x_scale_reg   <= 12'd0;
            y_scale_reg   <= 12'd0;
            halfline_reg  <= 21'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_EXEC && sync_start)
                div_cnt_reg <= DIV_LAST_BIT;
            else if (state_reg == ST_DIV && div_cnt_reg != '0)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            // The final division step writes the quotient.
            if (state_reg == ST_DIV && div_cnt_reg == '0)
                halfline_reg <= {div_quo_reg, div_ge};

            // Register write effects.
            if (state_reg == ST_EXEC && mode_reg == MODE_WRITE)
            begin
                case (index_reg)
                    REG_CTRL:    control_reg   <= wdata_reg;
                    REG_ORIGIN:  origin_reg    <= wdata_reg[23:0];
                    REG_WIDTH:   stride_reg    <= wdata_reg[11:0];
                    REG_V_INTR:  intr_line_reg <= wdata_reg[9:0];
                    REG_H_VIDEO:
                    begin
                        h_end_reg   <= wdata_reg[9:0];
                        h_start_reg <= wdata_reg[25:16];
                    end
                    REG_V_VIDEO:
                    begin
                        v_end_reg   <= wdata_reg[9:0];
                        v_start_reg <= wdata_reg[25:16];
                    end
                    REG_X_SCALE: x_scale_reg   <= wdata_reg[11:0];
                    REG_Y_SCALE: y_scale_reg   <= wdata_reg[11:0];
                    default:     ;
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            index_reg <= reg_index;
            wdata_reg <= write_data;
            px_reg    <= pixel_x;
            py_reg    <= pixel_y;
            raw_reg   <= pixel_raw;
        end

        if (state_reg == ST_EXEC)
        begin
            rdata_work_reg <= (mode_reg == MODE_READ) ? read_mux : 32'd0;
            irq_work_reg   <= (mode_reg == MODE_WRITE) && (index_reg == REG_V_CURRENT);
            div_den_reg    <= wdata_reg[31:1];
            div_rem_reg    <= 21'd0;
            div_quo_reg    <= 20'd0;
        end

        if (state_reg == ST_DIV)
        begin
            div_rem_reg <= div_ge ? div_diff[20:0] : div_trial[20:0];
            div_quo_reg <= {div_quo_reg[18:0], div_ge};
        end

        if (state_reg == ST_MADR)
            pix_index_reg <= mul_p + {12'd0, px_reg};

        if (state_reg == ST_MWID)
            dw_work_reg <= mul_p[21:10];

        // The height is held aside so a result still waiting is not disturbed.
        if (state_reg == ST_MHGT)
            dh_work_reg <= mul_p[20:10];

        if (out_load)
        begin
            read_data_reg      <= rdata_work_reg;
            irq_clear_reg      <= irq_work_reg;
            pixel_address_reg  <= (mode_reg == MODE_LOCATE && pix_ok) ? addr_calc : 24'd0;
            pixel_color_reg    <= (mode_reg == MODE_CONVERT && pix_ok) ? color_calc : 32'd0;
            pixel_valid_reg    <= pix_ok;
            display_width_reg  <= dw_work_reg;
            display_height_reg <= dh_work_reg;
            halfline_out_reg   <= halfline_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign irq_clear       = irq_clear_reg;
    assign pixel_address   = pixel_address_reg;
    assign pixel_color     = pixel_color_reg;
    assign pixel_valid     = pixel_valid_reg;
    assign display_width   = display_width_reg;
    assign display_height  = display_height_reg;
    assign halfline_cycles = halfline_out_reg;

    // Checks on the sequencer and result formation.
    `ASSERT_NEXT(a_fire_to_exec, in_fire, state_reg == ST_EXEC, "accepted word did not start")
    `ASSERT_SAME(a_div_cnt_range, state_reg == ST_DIV, div_cnt_reg <= DIV_LAST_BIT,
                 "divider step count out of range")
    `ASSERT_NEXT(a_div_stalls_input, state_reg == ST_DIV, !in_ready,
                 "input accepted during division")
    `ASSERT_SAME(a_irq_only_write, out_valid_reg && irq_clear_reg,
                 read_data_reg == 32'd0 && pixel_address_reg == 24'd0 && pixel_color_reg == 32'd0,
                 "interrupt clear with non-write payload")

endmodule

// ===== dv/video_interface_registers_checker.sv =====
`timescale 1ns / 1ps

module video_interface_registers_checker
    import vir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic [31:0] pixel_raw,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] read_data,
    input  logic        irq_clear,
    input  logic [23:0] pixel_address,
    input  logic [31:0] pixel_color,
    input  logic        pixel_valid,
    input  logic [11:0] display_width,
    input  logic [10:0] display_height,
    input  logic [20:0] halfline_cycles,
    output int          pending_results,
    output int          results_checked,
    output int          mismatch_count
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic [23:0] addr;
        logic [31:0] color;
        logic        pvalid;
        logic [11:0] dwidth;
        logic [10:0] dheight;
        logic [20:0] halfline;
    } vi_result_t;

    // Results predicted for accepted words, oldest first.
    vi_result_t expected_results[$];

    // Shadow copy of the register bank.
    logic [31:0] ctrl_q;
    logic [23:0] origin_q;
    logic [11:0] stride_q;
    logic [9:0]  intr_line_q;
    logic [9:0]  hstart_q;
    logic [9:0]  hend_q;
    logic [9:0]  vstart_q;
    logic [9:0]  vend_q;
    logic [11:0] xscale_q;
    logic [11:0] yscale_q;
    logic [20:0] halfline_q;

    // Apply one word to the shadow registers and work out its result.
    task automatic apply_word(input logic [1:0] op, input logic [3:0] idx,
                              input logic [31:0] wdata, input logic [11:0] px,
                              input logic [11:0] py, input logic [31:0] raw,
                              output vi_result_t res);
        logic [31:0] divisor;
        logic [1:0]  pmode;
        logic [63:0] offset;
        logic [15:0] swapped;
        logic [9:0]  span;
        logic [11:0] scale;
        logic [31:0] product;
        res = '0;
        if (op == MODE_READ)
        begin
            case (idx)
                REG_CTRL:    res.rdata = ctrl_q;
                REG_ORIGIN:  res.rdata = {8'd0, origin_q};
                REG_WIDTH:   res.rdata = {20'd0, stride_q};
                REG_V_INTR:  res.rdata = {22'd0, intr_line_q};
                REG_H_VIDEO: res.rdata = {6'd0, hstart_q, 6'd0, hend_q};
                REG_V_VIDEO: res.rdata = {6'd0, vstart_q, 6'd0, vend_q};
                REG_X_SCALE: res.rdata = {20'd0, xscale_q};
                REG_Y_SCALE: res.rdata = {20'd0, yscale_q};
                default:     res.rdata = '0;
            endcase
        end
        else if (op == MODE_WRITE)
        begin
            case (idx)
                REG_CTRL:      ctrl_q = wdata;
                REG_ORIGIN:    origin_q = wdata[23:0];
                REG_WIDTH:     stride_q = wdata[11:0];
                REG_V_INTR:    intr_line_q = wdata[9:0];
                REG_V_CURRENT: res.irq = 1'b1;
                REG_V_SYNC:
                begin
                    // A zero divisor keeps the previous halfline count.
                    divisor = wdata >> 1;
                    if (divisor != 0)
                        halfline_q = 21'(32'(SYNC_NUMERATOR) / divisor);
                end
                REG_H_VIDEO:
                begin
                    hend_q   = wdata[9:0];
                    hstart_q = wdata[25:16];
                end
                REG_V_VIDEO:
                begin
                    vend_q   = wdata[9:0];
                    vstart_q = wdata[25:16];
                end
                REG_X_SCALE:   xscale_q = wdata[11:0];
                REG_Y_SCALE:   yscale_q = wdata[11:0];
                default:       ;
            endcase
        end

        // Pixel helpers only work in the 16-bit and 32-bit formats.
        pmode = ctrl_q[1:0];
        res.pvalid = pmode[1];
        if (op == MODE_LOCATE && res.pvalid)
        begin
            offset = 64'(py) * 64'(stride_q) + 64'(px);
            offset = (pmode == PMODE_32) ? offset << 2 : offset << 1;
            res.addr = 24'(64'(origin_q) + offset);
        end
        else if (op == MODE_CONVERT && res.pvalid)
        begin
            if (pmode == PMODE_32)
                res.color = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            else
            begin
                swapped = {raw[7:0], raw[15:8]};
                res.color = {8'hFF, swapped[5:1], swapped[5:3],
                             swapped[10:6], swapped[10:8],
                             swapped[15:11], swapped[15:13]};
            end
        end

        // Display size; a start beyond its end counts as an empty span.
        span = (hend_q > hstart_q) ? hend_q - hstart_q : 10'd0;
        scale = (xscale_q != 0) ? xscale_q : DEFAULT_SCALE;
        product = 32'(span) * 32'(scale);
        res.dwidth = 12'(product >> 10);
        span = (vend_q > vstart_q) ? (vend_q - vstart_q) >> 1 : 10'd0;
        scale = (yscale_q != 0) ? yscale_q : DEFAULT_SCALE;
        product = 32'(span) * 32'(scale);
        res.dheight = 11'(product >> 10);
        res.halfline = halfline_q;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // Predict on every accepted input word and check every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        vi_result_t predicted;
        vi_result_t oldest;
        if (!rst_n)
        begin
            ctrl_q          = '0;
            origin_q        = '0;
            stride_q        = '0;
            intr_line_q     = INTR_LINE_RESET;
            hstart_q        = '0;
            hend_q          = '0;
            vstart_q        = '0;
            vend_q          = '0;
            xscale_q        = '0;
            yscale_q        = '0;
            halfline_q      = '0;
            expected_results.delete();
            pending_results = 0;
            results_checked = 0;
            mismatch_count  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_word(mode, reg_index, write_data, pixel_x, pixel_y,
                           pixel_raw, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result word with no word pending", $time);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("read_data", read_data, oldest.rdata);
                    compare_field("irq_clear", 32'(irq_clear), 32'(oldest.irq));
                    compare_field("pixel_address", 32'(pixel_address),
                                  32'(oldest.addr));
                    compare_field("pixel_color", pixel_color, oldest.color);
                    compare_field("pixel_valid", 32'(pixel_valid),
                                  32'(oldest.pvalid));
                    compare_field("display_width", 32'(display_width),
                                  32'(oldest.dwidth));
                    compare_field("display_height", 32'(display_height),
                                  32'(oldest.dheight));
                    compare_field("halfline_cycles", 32'(halfline_cycles),
                                  32'(oldest.halfline));
                    results_checked++;
                end
            end
            pending_results = expected_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vir_pkg::*;

    localparam int RANDOM_WORDS = 1700;
    localparam int QUIET_WORDS  = 200;
    localparam int STALL_AT     = 300;
    localparam int DRAIN_AT     = 700;
    localparam int LONG_STALL   = 300;
    localparam int END_CYCLES   = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // A register that the block accepts but does not keep.
    localparam logic [3:0] REG_BURST = 4'd5;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_raw;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        irq_clear;
    logic [23:0] pixel_address;
    logic [31:0] pixel_color;
    logic        pixel_valid;
    logic [11:0] display_width;
    logic [10:0] display_height;
    logic [20:0] halfline_cycles;
    int          pending_results;
    int          results_checked;
    int          mismatch_count;

    int   cycle_count;
    int   words_by_mode[4];
    int   sync_writes;
    int   stall_requests;
    logic quiet_phase;

    video_interface_registers dut (.*);

    video_interface_registers_checker vir_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                             input logic [31:0] wdata, input logic [11:0] px,
                             input logic [11:0] py, input logic [31:0] raw);
        in_valid   <= 1'b1;
        mode       <= op;
        reg_index  <= idx;
        write_data <= wdata;
        pixel_x    <= px;
        pixel_y    <= py;
        pixel_raw  <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        words_by_mode[op]++;
        if (op == MODE_WRITE && idx == REG_V_SYNC)
            sync_writes++;
    endtask

    task automatic send_write(input logic [3:0] idx, input logic [31:0] wdata);
        send_word(MODE_WRITE, idx, wdata, 12'($urandom()), 12'($urandom()),
                  $urandom());
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_word(MODE_READ, idx, $urandom(), 12'($urandom()), 12'($urandom()),
                  $urandom());
    endtask

    // Pause the input until every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
    endtask

    // Field extremes, every operation and the corner cases.
    task automatic run_directed();
        send_read(REG_V_INTR);
        send_word(MODE_LOCATE, REG_CTRL, '0, 12'hFFF, 12'hFFF, '0);
        send_word(MODE_CONVERT, REG_CTRL, '0, '0, '0, 32'hFFFF_FFFF);
        // Sync writes whose divisor is zero leave the count alone.
        send_write(REG_V_SYNC, 32'd0);
        send_write(REG_V_SYNC, 32'd1);
        send_write(REG_V_SYNC, 32'd2);
        send_write(REG_V_SYNC, 32'hFFFF_FFFF);
        send_write(REG_V_CURRENT, 32'hFFFF_FFFF);
        send_read(REG_V_CURRENT);
        send_write(REG_BURST, 32'hFFFF_FFFF);
        send_read(REG_BURST);
        // Start above end gives an empty span.
        send_write(REG_H_VIDEO, 32'h03FF_0000);
        send_write(REG_H_VIDEO, 32'h0000_03FF);
        send_write(REG_V_VIDEO, 32'h0000_03FF);
        send_write(REG_X_SCALE, 32'hFFFF_FFFF);
        send_write(REG_Y_SCALE, 32'hFFFF_FFFF);
        send_write(REG_ORIGIN, 32'hFFFF_FFFF);
        send_write(REG_WIDTH, 32'hFFFF_FFFF);
        send_write(REG_V_INTR, 32'hFFFF_FFFF);
        send_write(REG_CTRL, 32'hFFFF_FFFF);
        send_read(REG_H_VIDEO);
        send_word(MODE_LOCATE, REG_CTRL, '0, 12'hFFF, 12'hFFF, '0);
        send_word(MODE_CONVERT, REG_CTRL, '0, '0, '0, 32'h1234_5678);
        send_write(REG_CTRL, 32'h0000_0002);
        send_word(MODE_LOCATE, REG_CTRL, '0, 12'hFFF, 12'hFFF, '0);
        send_word(MODE_CONVERT, REG_CTRL, '0, '0, '0, 32'h0000_01F8);
    endtask

    // Random word, weighted toward the decoded registers and useful data.
    task automatic send_random_word();
        int          pick;
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] wdata;
        logic [9:0]  span_end;
        logic [9:0]  span_start;
        pick = $urandom_range(0, 99);
        op = (pick < 25) ? MODE_READ : (pick < 55) ? MODE_WRITE :
             (pick < 80) ? MODE_LOCATE : MODE_CONVERT;
        if ($urandom_range(0, 3) == 0)
            idx = 4'($urandom_range(0, 15));
        else
        begin
            case ($urandom_range(0, 9))
                0:       idx = REG_CTRL;
                1:       idx = REG_ORIGIN;
                2:       idx = REG_WIDTH;
                3:       idx = REG_V_INTR;
                4:       idx = REG_V_CURRENT;
                5:       idx = REG_V_SYNC;
                6:       idx = REG_H_VIDEO;
                7:       idx = REG_V_VIDEO;
                8:       idx = REG_X_SCALE;
                default: idx = REG_Y_SCALE;
            endcase
        end
        wdata = $urandom();
        if (op == MODE_WRITE)
        begin
            case (idx)
                REG_CTRL:
                    wdata[1:0] = ($urandom_range(0, 3) != 0) ?
                                 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
                REG_V_SYNC:
                    if ($urandom_range(0, 1) == 1)
                        wdata = $urandom_range(0, 4000);
                REG_H_VIDEO, REG_V_VIDEO:
                    if ($urandom_range(0, 2) != 0)
                    begin
                        span_end = 10'($urandom());
                        span_start = 10'($urandom_range(0, span_end));
                        wdata[25:16] = span_start;
                        wdata[9:0] = span_end;
                    end
                REG_X_SCALE, REG_Y_SCALE:
                    if ($urandom_range(0, 3) == 0)
                        wdata[11:0] = '0;
                default: ;
            endcase
        end
        send_word(op, idx, wdata, 12'($urandom()), 12'($urandom()), $urandom());
    endtask

    // Output side: random stall bursts plus one long stall on request.
    initial
    begin
        int stall_left;
        int stalls_done;
        int stretch_left;
        bit stall_on;
        out_ready = 1'b0;
        stall_left = 0;
        stalls_done = 0;
        stretch_left = 0;
        stall_on = 1'b1;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                stall_on = ($urandom_range(0, 2) != 0);
                stretch_left = $urandom_range(100, 300);
            end
            else
                stretch_left--;
            if (!rst_n)
                out_ready <= 1'b0;
            else if (stall_requests != stalls_done)
            begin
                stalls_done++;
                out_ready <= 1'b0;
                stall_left = LONG_STALL;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (stall_on && !quiet_phase && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Input side and verdict.
    initial
    begin
        bit idle_on;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_READ;
        reg_index      = '0;
        write_data     = '0;
        pixel_x        = '0;
        pixel_y        = '0;
        pixel_raw      = '0;
        quiet_phase    = 1'b0;
        stall_requests = 0;
        sync_writes    = 0;
        idle_on        = 1'b1;
        for (int m = 0; m < 4; m++)
            words_by_mode[m] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 150 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (i == STALL_AT)
                stall_requests <= stall_requests + 1;
            if (i == RANDOM_WORDS - QUIET_WORDS)
                quiet_phase <= 1'b1;
            if (i == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            else if (idle_on && i < RANDOM_WORDS - QUIET_WORDS &&
                     $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            send_random_word();
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d words: %0d reads, %0d writes (%0d sync), %0d locates, %0d converts",
                 words_by_mode[0] + words_by_mode[1] + words_by_mode[2] + words_by_mode[3],
                 words_by_mode[MODE_READ], words_by_mode[MODE_WRITE], sync_writes,
                 words_by_mode[MODE_LOCATE], words_by_mode[MODE_CONVERT]);
        $display("Checked %0d results with %0d mismatches, one long output stall, one drain",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vir_pkg.sv
rtl/video_interface_registers.sv
dv/video_interface_registers_checker.sv
dv/tb.sv
